// ===== rtl/bxma_pkg.sv =====
// shared types and fixed constants of the boxcar moving average
package bxma_pkg;

    // width of the window length register
    localparam int CFG_W = 9;

    // window length after reset
    localparam int CFG_RESET = 16;

    // operation carried in the op field of an input word
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_FILL = 1'b1
    } op_t;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/bxma_ram.sv =====
// generic simple dual-port ram with registered read
module bxma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bxma_div.sv =====
// restoring divider of a signed sum by an unsigned length, truncating toward zero
module bxma_div #(
    parameter int SUM_W = 24,
    parameter int LEN_W = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [LEN_W-1:0]         divisor,
    output bxma_pkg::div_status_t    status,
    output logic signed [SUM_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] dvs_reg, dvs_next;

    logic [SUM_W-1:0] magnitude;
    logic [LEN_W:0]   shifted;
    logic [LEN_W:0]   trial;
    logic             fits;

    // magnitude of the dividend, the most negative sum still fits unsigned
    assign magnitude = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

    // one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(SUM_W);
            neg_next  = dividend[SUM_W-1];
            quo_next  = magnitude;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // sign correction of the quotient
    assign quotient    = neg_reg ? $signed(~quo_reg + 1'b1) : $signed(quo_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/boxcar_moving_average.sv =====
// boxcar moving average over a ring of samples held in a ram
//
// input channel in_valid/in_ready carries a word of op and value. op 0
// pushes value into the ring in place of the oldest sample and returns
// one average word on out_valid/out_ready: the running window sum divided
// by the window length, truncated toward zero. op 1 fills every active
// entry with value and returns no word.
// a push runs from acceptance to the next acceptance through a ram read,
// an update of the sum with the write back, the bit-serial divider over
// the SUM_W-bit sum (24 bits at default parameters) and the load of the
// output register; no new word is accepted before that load.
// out_valid rises as the output register loads the average word.
// a fill makes one ram write per active entry.
// after reset, and after every write of window_len on cfg_we/cfg_wdata,
// a clearing pass writes zero to all WINDOW_MAX entries, one per cycle,
// with in_ready low; the sum and the write position start at zero.
// a finished average waits in the output register while out_ready is
// low, so the next word is still accepted; a second average waits in the
// divider until the first one is taken.
module boxcar_moving_average #(
    parameter int WINDOW_MAX   = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bxma_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic signed [SAMPLE_WIDTH-1:0] value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] average
);

    localparam int ADDR_W    = $clog2(WINDOW_MAX);
    localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W     = SAMPLE_WIDTH + ADDR_W;
    localparam int PROD_W    = SAMPLE_WIDTH + LEN_W + 1;
    localparam int LEN_RESET = (bxma_pkg::CFG_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                                  : bxma_pkg::CFG_RESET;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FILL  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic [ADDR_W-1:0]         cnt_reg, cnt_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_WIDTH-1:0] average_reg, average_next;

    logic                      in_accept;
    logic [31:0]               cfg_wide;
    logic [LEN_W-1:0]          cfg_len;
    logic signed [PROD_W-1:0]  fill_prod;
    logic [LEN_W-1:0]          pos_inc;
    logic signed [SUM_W-1:0]   push_sum;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [SAMPLE_WIDTH-1:0]   ram_wdata;
    logic [SAMPLE_WIDTH-1:0]   ram_rdata;

    logic                      div_start;
    bxma_pkg::div_status_t     div_stat;
    logic signed [SUM_W-1:0]   div_quo;
    logic                      out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // effective window length: zero counts as one, saturate at the ring depth
    assign cfg_wide = 32'(cfg_wdata);
    always_comb
    begin
        priority if (cfg_wide == 32'd0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if (cfg_wide > 32'(WINDOW_MAX))
        begin
            cfg_len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            cfg_len = LEN_W'(cfg_wdata);
        end
    end

    // fill sum is value times length, running sum for a push
    assign fill_prod = value * $signed({1'b0, len_reg});
    assign push_sum  = sum_reg + SUM_W'(sample_reg) - SUM_W'($signed(ram_rdata));
    assign pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);

    // output register loads once the divider is done and the slot is free
    assign out_load = (state_reg == ST_DIV) && div_stat.done
                      && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        average_next   = average_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            average_next   = div_quo[SAMPLE_WIDTH-1:0];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            state_next = ST_CLEAR;
            len_next   = cfg_len;
            pos_next   = '0;
            cnt_next   = '0;
            sum_next   = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ADDR_W'(WINDOW_MAX - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        sample_next = value;
                        if (op == bxma_pkg::OP_FILL)
                        begin
                            sum_next   = fill_prod[SUM_W-1:0];
                            pos_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    sum_next   = push_sum;
                    div_start  = 1'b1;
                    pos_next   = (pos_inc == len_reg) ? '0 : pos_inc[ADDR_W-1:0];
                    state_next = ST_DIV;
                end
                ST_DIV:
                begin
                    if (out_load)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_FILL:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if ((LEN_W'(cnt_reg) + LEN_W'(1)) == len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_CLEAR;
                end
            endcase
        end
    end

    // ram port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = sample_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
            end
            ST_READ:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            len_reg       <= LEN_W'(LEN_RESET);
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        average_reg <= average_next;
    end

    // sample ring
    bxma_ram #(
        .WIDTH(SAMPLE_WIDTH),
        .DEPTH(WINDOW_MAX)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (in_accept),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    // window sum divided by length
    bxma_div #(
        .SUM_W(SUM_W),
        .LEN_W(LEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(sum_next),
        .divisor (len_reg),
        .status  (div_stat),
        .quotient(div_quo)
    );

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // write position stays inside the active window
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < {1'b0, len_reg})
        else $error("write position outside window");

    // divider never restarted while it works
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a new average appears only from the divide state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DIV))
        else $error("average word without a divide");

    // a length write restarts the clearing pass with an empty sum
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == ST_CLEAR) && (sum_reg == '0) && (pos_reg == '0))
        else $error("length write did not clear the store");

endmodule

// ===== verif/boxcar_moving_average_tb.sv =====
// self-checking testbench of the boxcar moving average with a ring predictor
module boxcar_moving_average_tb;

    localparam int WINDOW_MAX   = 256;
    localparam int SAMPLE_W     = 16;
    localparam int LIMIT_CYCLES = 600000;
    // longest fill, with margin
    localparam int SETTLE_CYCLES = 300;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [bxma_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       op = 1'b0;
    logic signed [SAMPLE_W-1:0] value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] average;

    // predictor state: ring of samples, write position, running sum
    logic signed [SAMPLE_W-1:0] ring_model [0:WINDOW_MAX-1];
    int                         ring_wpos;
    longint                     ring_sum;
    int                         ring_len;

    // averages still owed by the block, oldest first
    logic signed [SAMPLE_W-1:0] avg_q [$];

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_stall_en = 1'b0;
    int  rx_hold = 0;
    int  rx_gap = 0;

    boxcar_moving_average i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .average   (average)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("[boxcar_moving_average] ERROR");
            $finish;
        end
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // sample value biased toward the extremes and toward values near zero
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'($signed($urandom_range(0, 20)) - 10);
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    // effective window after a register write, store cleared
    function automatic void ring_configure(logic [bxma_pkg::CFG_W-1:0] len);
        if (len == 0)
            ring_len = 1;
        else if (len > WINDOW_MAX)
            ring_len = WINDOW_MAX;
        else
            ring_len = len;
        for (int i = 0; i < WINDOW_MAX; i++)
            ring_model[i] = '0;
        ring_wpos = 0;
        ring_sum = 0;
    endfunction

    // fill the active entries with one value
    function automatic void ring_fill(logic signed [SAMPLE_W-1:0] v);
        for (int i = 0; i < ring_len; i++)
            ring_model[i] = v;
        ring_sum = longint'(v) * ring_len;
        ring_wpos = 0;
    endfunction

    // replace the oldest sample and return the truncated average
    function automatic logic signed [SAMPLE_W-1:0] ring_push(logic signed [SAMPLE_W-1:0] v);
        longint q;
        if (ring_wpos >= ring_len)
            ring_wpos = 0;
        ring_sum = ring_sum + longint'(v) - longint'(ring_model[ring_wpos]);
        ring_model[ring_wpos] = v;
        ring_wpos = (ring_wpos + 1) % ring_len;
        q = ring_sum / longint'(ring_len);
        return q[SAMPLE_W-1:0];
    endfunction

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold--;
            end
            else if (rx_gap > 0)
            begin
                out_ready = 1'b0;
                rx_gap--;
            end
            else
            begin
                out_ready = 1'b1;
                if (rx_stall_en)
                    rx_gap = pick_gap();
            end
        end
    end

    // compare each average word with the oldest expectation
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] exp_avg;
        if (rst_n && out_valid && out_ready)
        begin
            if (avg_q.size() == 0)
            begin
                $error("average: no word expected, got %0d", average);
                err_cnt++;
            end
            else
            begin
                exp_avg = avg_q.pop_front();
                if (average !== exp_avg)
                begin
                    $error("average: expected %0d, actual %0d", exp_avg, average);
                    err_cnt++;
                end
            end
        end
    end

    // offer one word and wait for it to be taken; returns at the next falling edge
    task automatic send_word(bxma_pkg::op_t o, logic signed [SAMPLE_W-1:0] v);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op = o;
        value = v;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (o == bxma_pkg::OP_FILL)
            ring_fill(v);
        else
            avg_q.push_back(ring_push(v));
        @(negedge clk);
    endtask

    // stop offering and wait until every average has come out
    task automatic wait_drained();
        in_valid = 1'b0;
        wait (avg_q.size() == 0);
        @(negedge clk);
    endtask

    // new window length, written only once the block is idle
    task automatic write_window(logic [bxma_pkg::CFG_W-1:0] len);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wdata = len;
        cfg_we = 1'b1;
        ring_configure(len);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // reset window of 16: extremes, truncation toward zero, fills
    task automatic test_default_window();
        send_word(bxma_pkg::OP_PUSH, 16'sh7FFF);
        send_word(bxma_pkg::OP_PUSH, 16'sh8000);
        send_word(bxma_pkg::OP_PUSH, -16'sd1);
        send_word(bxma_pkg::OP_PUSH, 16'sd0);
        send_word(bxma_pkg::OP_FILL, 16'sh7FFF);
        send_word(bxma_pkg::OP_PUSH, 16'sh7FFF);
        send_word(bxma_pkg::OP_FILL, 16'sh8000);
        send_word(bxma_pkg::OP_PUSH, 16'sh8000);
        send_word(bxma_pkg::OP_PUSH, 16'sh7FFF);
        send_word(bxma_pkg::OP_FILL, 16'sd0);
        send_word(bxma_pkg::OP_PUSH, -16'sd17);
        wait_drained();
    endtask

    // window length at one, the maximum, zero and above the maximum
    task automatic test_window_limits();
        write_window(9'd1);
        send_word(bxma_pkg::OP_PUSH, 16'sd5);
        send_word(bxma_pkg::OP_PUSH, 16'sh8000);
        send_word(bxma_pkg::OP_FILL, 16'sd7);
        send_word(bxma_pkg::OP_PUSH, 16'sd3);
        write_window(9'd256);
        send_word(bxma_pkg::OP_FILL, 16'sh7FFF);
        send_word(bxma_pkg::OP_PUSH, 16'sh8000);
        send_word(bxma_pkg::OP_PUSH, 16'sh7FFF);
        write_window(9'd0);
        send_word(bxma_pkg::OP_PUSH, 16'sd100);
        send_word(bxma_pkg::OP_PUSH, -16'sd3);
        write_window(9'd511);
        send_word(bxma_pkg::OP_PUSH, 16'sh7FFF);
        send_word(bxma_pkg::OP_FILL, -16'sd1);
        send_word(bxma_pkg::OP_PUSH, 16'sd1);
        wait_drained();
    endtask

    // random pushes and fills over a range of window lengths
    task automatic test_random_windows();
        logic [bxma_pkg::CFG_W-1:0] lens [15];
        int                         n;
        lens = '{9'd3, 9'd1, 9'd2, 9'd16, 9'd5, 9'd256, 9'd8, 9'd0,
                 9'd31, 9'd511, 9'd7, 9'd300, 9'd4, 9'd255, 9'd12};
        foreach (lens[k])
        begin
            write_window(lens[k]);
            // some phases run without any idling
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            n = $urandom_range(30, 45);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_word(bxma_pkg::OP_FILL, pick_sample());
                else
                    send_word(bxma_pkg::OP_PUSH, pick_sample());
            end
        end
        wait_drained();
    endtask

    // long receiver hold-off while the sender keeps offering words
    task automatic test_backpressure();
        write_window(9'd6);
        tx_idle_en = 1'b0;
        rx_stall_en = 1'b0;
        rx_hold = 400;
        for (int i = 0; i < 12; i++)
            send_word(bxma_pkg::OP_PUSH, pick_sample());
        // sender pauses until every average is out
        wait_drained();
        tx_idle_en = 1'b1;
        rx_stall_en = 1'b1;
        for (int i = 0; i < 20; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(bxma_pkg::OP_FILL, pick_sample());
            else
                send_word(bxma_pkg::OP_PUSH, pick_sample());
        end
        wait_drained();
    endtask

    initial
    begin
        ring_configure(bxma_pkg::CFG_W'(bxma_pkg::CFG_RESET));
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_default_window();
        test_window_limits();
        test_random_windows();
        test_backpressure();
        wait_drained();
        repeat (60) @(negedge clk);
        if (err_cnt == 0 && avg_q.size() == 0)
            $display("[boxcar_moving_average] OK");
        else
            $display("[boxcar_moving_average] ERROR");
        $finish;
    end

endmodule
